FILE: rtl/dq_pkg.sv
// Package for the double-ended queue: request types, operation and status codes,
// cell control struct and the sequencer states.
// Has no dependencies. It must be compiled before every other file in rtl.
package dq_pkg;

    typedef logic signed [31:0] t_key;

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_SEARCH     = 3'd4;
    localparam logic [2:0] MODE_CLEAR      = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0] mode;
        t_key       key;
    } t_in_req;

    typedef struct packed {
        logic [1:0] status;
        t_key       value;
        logic [3:0] position;
        logic [4:0] count;
        t_key       front_value;
        t_key       back_value;
    } t_out_req;

    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic clear;
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } t_state;

endpackage

FILE: rtl/dq_cell.sv
// One storage cell of the queue chain. It holds one element and its valid bit.
// It exchanges data with both neighbors. It depends on dq_pkg.
module dq_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dq_pkg::t_cell_op i_op,
    input  dq_pkg::t_key     i_key,
    input  dq_pkg::t_key     i_left_data,
    input  logic             i_left_valid,
    input  dq_pkg::t_key     i_right_data,
    input  logic             i_right_valid,
    output dq_pkg::t_key     o_data,
    output logic             o_valid,
    output logic             o_match,
    output logic             o_last
);

    dq_pkg::t_key r_data;
    dq_pkg::t_key n_data;
    logic         r_valid;
    logic         n_valid;

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_last  = r_valid && !i_right_valid;
    assign o_match = r_valid && (r_data == i_key);

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        priority if (i_op.clear) begin
            n_valid = 1'b0;
        end else if (i_op.push_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_op.push_back) begin
            if (!r_valid && i_left_valid) begin
                n_data  = i_key;
                n_valid = 1'b1;
            end
        end else if (i_op.pop_front) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_op.pop_back) begin
            if (o_last) begin
                n_valid = 1'b0;
            end
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

FILE: rtl/double_ended_queue.sv
// When a request is taken, the chain of DEPTH cells shifts, appends, drops or clears
// elements, and every cell compares its element with the search key. In the finishing
// state the first match is encoded and the result is formed. The result is then loaded
// into the output register when that is free. A new request is taken once the result is
// loaded. The output can hold one result while the next request is being worked on. The
// queue holds DEPTH elements, and a push while it is full is answered with the full status.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  dq_pkg::t_in_req  i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output dq_pkg::t_out_req o_out_req
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dq_pkg::t_state   r_state;
    dq_pkg::t_state   n_state;
    dq_pkg::t_cell_op cell_op;
    dq_pkg::t_key     w_data [DEPTH];
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_match;
    logic [DEPTH-1:0] w_last;
    dq_pkg::t_key     back_data;
    dq_pkg::t_key     front_data;
    logic             full;
    logic             empty;
    logic             in_accept;
    logic             out_free;
    logic             finish;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    dq_pkg::t_key     r_value;
    dq_pkg::t_key     n_value;
    logic             r_search;
    logic [DEPTH-1:0] r_match;
    logic [IW-1:0]    first_pos;
    dq_pkg::t_out_req result;
    dq_pkg::t_out_req r_out;
    logic             r_out_valid;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != dq_pkg::ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign finish      = (r_state == dq_pkg::ST_FINISH) && out_free;
    assign full        = w_valid[DEPTH-1];
    assign empty       = !w_valid[0];
    assign front_data  = w_valid[0] ? w_data[0] : '0;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dq_pkg::t_key left_data;
        dq_pkg::t_key right_data;
        logic         left_valid;
        logic         right_valid;

        if (g == 0) begin : g_head
            assign left_data  = i_in_req.key;
            assign left_valid = 1'b1;
        end else begin : g_inner_left
            assign left_data  = w_data[g-1];
            assign left_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner_right
            assign right_data  = w_data[g+1];
            assign right_valid = w_valid[g+1];
        end

        dq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (cell_op),
            .i_key         (i_in_req.key),
            .i_left_data   (left_data),
            .i_left_valid  (left_valid),
            .i_right_data  (right_data),
            .i_right_valid (right_valid),
            .o_data        (w_data[g]),
            .o_valid       (w_valid[g]),
            .o_match       (w_match[g]),
            .o_last        (w_last[g])
        );
    end

    always_comb begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_data = back_data | (w_last[i] ? w_data[i] : '0);
        end
    end

    always_comb begin
        cell_op  = '0;
        n_count  = r_count;
        n_status = dq_pkg::STATUS_OK;
        n_value  = '0;
        if (in_accept) begin
            unique case (i_in_req.mode)
                dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
                    if (full) begin
                        n_status = dq_pkg::STATUS_FULL;
                    end else begin
                        cell_op.push_front = (i_in_req.mode == dq_pkg::MODE_PUSH_FRONT);
                        cell_op.push_back  = (i_in_req.mode == dq_pkg::MODE_PUSH_BACK);
                        n_count = r_count + CW'(1);
                    end
                end
                dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK: begin
                    if (empty) begin
                        n_status = dq_pkg::STATUS_EMPTY;
                    end else begin
                        cell_op.pop_front = (i_in_req.mode == dq_pkg::MODE_POP_FRONT);
                        cell_op.pop_back  = (i_in_req.mode == dq_pkg::MODE_POP_BACK);
                        n_value = (i_in_req.mode == dq_pkg::MODE_POP_FRONT) ?
                                  w_data[0] : back_data;
                        n_count = r_count - CW'(1);
                    end
                end
                dq_pkg::MODE_CLEAR: begin
                    cell_op.clear = 1'b1;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        first_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                first_pos = IW'(i);
            end
        end
    end

    always_comb begin
        result.value       = r_value;
        result.count       = 5'(r_count);
        result.front_value = front_data;
        result.back_value  = back_data;
        if (r_search) begin
            result.status   = (|r_match) ? dq_pkg::STATUS_OK : dq_pkg::STATUS_NOT_FOUND;
            result.position = 4'(first_pos);
        end else begin
            result.status   = r_status;
            result.position = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dq_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = dq_pkg::ST_FINISH;
                end
            end
            dq_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = dq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dq_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_search <= (i_in_req.mode == dq_pkg::MODE_SEARCH);
            r_match  <= w_match;
        end
        if (finish) begin
            r_out <= result;
        end
    end

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_count) == $countones(w_valid)))
        else $error("element count differs from the number of valid cells");

    a_cells_packed_at_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((w_valid + DEPTH'(1)) & w_valid) == '0))
        else $error("valid cells do not form a run from the front");

    a_accept_moves_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == dq_pkg::ST_FINISH))
        else $error("accepted request did not enter the finishing cycle");

    a_search_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_req.mode == dq_pkg::MODE_SEARCH)) |=> $stable(r_count))
        else $error("search changed the element count");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue: directed and random requests,
// an internal deque predictor and a request-by-request comparison of every result.
// Depends on dq_pkg and the double_ended_queue RTL.
module tb;

    localparam int DEQUE_DEPTH = 16;
    localparam int RANDOM_REQUESTS = 925;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 80;
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    logic             i_clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    dq_pkg::t_in_req  in_req = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    dq_pkg::t_out_req out_req;

    dq_pkg::t_in_req  request_backlog[$];
    dq_pkg::t_out_req expected_results[$];
    logic [2:0]       expected_modes[$];

    dq_pkg::t_key deque_slot [DEQUE_DEPTH];
    logic [3:0]   deque_head = '0;
    logic [4:0]   deque_fill = '0;

    int gen_fill = 0;
    dq_pkg::t_key key_pool[$];

    int error_count = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int outputs_taken = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int full_seen = 0;
    int empty_seen = 0;
    int miss_seen = 0;
    int hit_seen = 0;
    int peak_fill = 0;

    double_ended_queue #(
        .DEPTH(DEQUE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic dq_pkg::t_out_req deque_apply(input dq_pkg::t_in_req req);
        dq_pkg::t_out_req res;
        logic [3:0] idx;
        bit found;
        res = '0;
        found = 1'b0;
        case (req.mode)
            dq_pkg::MODE_PUSH_FRONT: begin
                if (deque_fill == 5'(DEQUE_DEPTH)) begin
                    res.status = dq_pkg::STATUS_FULL;
                end else begin
                    deque_head = deque_head - 4'd1;
                    deque_slot[deque_head] = req.key;
                    deque_fill = deque_fill + 5'd1;
                end
            end
            dq_pkg::MODE_PUSH_BACK: begin
                if (deque_fill == 5'(DEQUE_DEPTH)) begin
                    res.status = dq_pkg::STATUS_FULL;
                end else begin
                    idx = deque_head + deque_fill[3:0];
                    deque_slot[idx] = req.key;
                    deque_fill = deque_fill + 5'd1;
                end
            end
            dq_pkg::MODE_POP_FRONT: begin
                if (deque_fill == 5'd0) begin
                    res.status = dq_pkg::STATUS_EMPTY;
                end else begin
                    res.value = deque_slot[deque_head];
                    deque_head = deque_head + 4'd1;
                    deque_fill = deque_fill - 5'd1;
                end
            end
            dq_pkg::MODE_POP_BACK: begin
                if (deque_fill == 5'd0) begin
                    res.status = dq_pkg::STATUS_EMPTY;
                end else begin
                    idx = deque_head + 4'(deque_fill - 5'd1);
                    res.value = deque_slot[idx];
                    deque_fill = deque_fill - 5'd1;
                end
            end
            dq_pkg::MODE_SEARCH: begin
                res.status = dq_pkg::STATUS_NOT_FOUND;
                for (int i = 0; i < deque_fill; i++) begin
                    idx = deque_head + 4'(i);
                    if (!found && deque_slot[idx] == req.key) begin
                        found = 1'b1;
                        res.status = dq_pkg::STATUS_OK;
                        res.position = 4'(i);
                    end
                end
            end
            dq_pkg::MODE_CLEAR: begin
                deque_head = '0;
                deque_fill = '0;
            end
            default: begin
            end
        endcase
        res.count = deque_fill;
        if (deque_fill != 5'd0) begin
            res.front_value = deque_slot[deque_head];
            idx = deque_head + 4'(deque_fill - 5'd1);
            res.back_value = deque_slot[idx];
        end
        return res;
    endfunction

    function automatic void queue_request(input logic [2:0] mode, input dq_pkg::t_key key);
        dq_pkg::t_in_req req;
        req.mode = mode;
        req.key = key;
        request_backlog.push_back(req);
        case (mode)
            dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
                if (gen_fill < DEQUE_DEPTH) begin
                    gen_fill++;
                    key_pool.push_back(key);
                    if (key_pool.size() > 24) begin
                        void'(key_pool.pop_front());
                    end
                end
            end
            dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK: begin
                if (gen_fill > 0) begin
                    gen_fill--;
                end
            end
            dq_pkg::MODE_CLEAR: gen_fill = 0;
            default: begin
            end
        endcase
    endfunction

    function automatic dq_pkg::t_key pick_key();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) begin
            case ($urandom_range(3))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return 32'sh0;
                default: return -32'sd1;
            endcase
        end else if (roll <= 3) begin
            return dq_pkg::t_key'(int'($urandom_range(8)) - 4);
        end
        return dq_pkg::t_key'($urandom);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    initial begin : stimulus
        bit filling;
        int roll;
        dq_pkg::t_key key;
        queue_request(dq_pkg::MODE_POP_FRONT, 32'sh0);
        queue_request(dq_pkg::MODE_POP_BACK, -32'sd1);
        queue_request(dq_pkg::MODE_SEARCH, 32'sh0);
        queue_request(dq_pkg::MODE_PUSH_BACK, 32'sh7FFFFFFF);
        queue_request(dq_pkg::MODE_PUSH_FRONT, 32'sh80000000);
        for (int i = 0; i < DEQUE_DEPTH - 2; i++) begin
            queue_request((i % 2) ? dq_pkg::MODE_PUSH_BACK : dq_pkg::MODE_PUSH_FRONT,
                          dq_pkg::t_key'(i % 5));
        end
        queue_request(dq_pkg::MODE_PUSH_FRONT, 32'sd1);
        queue_request(dq_pkg::MODE_PUSH_BACK, -32'sd1);
        queue_request(dq_pkg::MODE_SEARCH, 32'sd3);
        queue_request(dq_pkg::MODE_SEARCH, 32'sh12345678);
        queue_request(dq_pkg::MODE_CLEAR, 32'sh0);
        queue_request(MODE_SPARE_LO, 32'sh0);
        queue_request(MODE_SPARE_HI, -32'sd1);

        filling = 1'b1;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (gen_fill == DEQUE_DEPTH) begin
                filling = 1'b0;
            end else if (gen_fill == 0) begin
                filling = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 1) begin
                queue_request(dq_pkg::MODE_CLEAR, dq_pkg::t_key'($urandom));
            end else if (roll < 3) begin
                queue_request($urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO,
                              dq_pkg::t_key'($urandom));
            end else if (roll < 23) begin
                if (key_pool.size() != 0 && $urandom_range(9) < 7) begin
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                end else begin
                    key = pick_key();
                end
                queue_request(dq_pkg::MODE_SEARCH, key);
            end else if (($urandom_range(99) < 75) == filling) begin
                queue_request($urandom_range(1) ? dq_pkg::MODE_PUSH_BACK :
                              dq_pkg::MODE_PUSH_FRONT, pick_key());
            end else begin
                queue_request($urandom_range(1) ? dq_pkg::MODE_POP_BACK :
                              dq_pkg::MODE_POP_FRONT, dq_pkg::t_key'($urandom));
            end
        end

        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (request_backlog.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end
        $display("Ran %0d requests and checked %0d results, peak occupancy %0d.",
                 requests_sent, results_checked, peak_fill);
        $display("Saw %0d full rejects, %0d empty pops, %0d search hits, %0d misses.",
                 full_seen, empty_seen, hit_seen, miss_seen);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(deque_apply(in_req));
                expected_modes.push_back(in_req.mode);
                requests_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (request_backlog.size() != 0 &&
                    ((requests_sent >= 600 && requests_sent < 750) ||
                     $urandom_range(99) >= 12)) begin
                    in_req <= request_backlog.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                outputs_taken++;
            end
            if (!hold_done && outputs_taken >= 400) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else if (outputs_taken >= 600 && outputs_taken < 750) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 12);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        dq_pkg::t_out_req expected_res;
        logic [2:0] expected_mode;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("Result arrived with no request outstanding");
                error_count++;
            end else begin
                expected_res = expected_results.pop_front();
                expected_mode = expected_modes.pop_front();
                compare_field("status", 32'(expected_res.status), 32'(out_req.status));
                compare_field("value", expected_res.value, out_req.value);
                compare_field("position", 32'(expected_res.position), 32'(out_req.position));
                compare_field("count", 32'(expected_res.count), 32'(out_req.count));
                compare_field("front_value", expected_res.front_value, out_req.front_value);
                compare_field("back_value", expected_res.back_value, out_req.back_value);
                results_checked++;
                case (out_req.status)
                    dq_pkg::STATUS_FULL: full_seen++;
                    dq_pkg::STATUS_EMPTY: empty_seen++;
                    dq_pkg::STATUS_NOT_FOUND: miss_seen++;
                    default: begin
                    end
                endcase
                if (expected_mode == dq_pkg::MODE_SEARCH &&
                    out_req.status == dq_pkg::STATUS_OK) begin
                    hit_seen++;
                end
                if (out_req.count > peak_fill) begin
                    peak_fill = out_req.count;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
